// File: rtl/bwu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint/watchpoint unit package
// Table sizes, field widths, command, event and status codes, and the range
// helpers shared by the unit.
// ----------------------------------------------------------------------------
package bwu_pkg;

   localparam int NUM_BREAKPOINTS   = 4;
   localparam int NUM_READ_WATCHES  = 4;
   localparam int NUM_WRITE_WATCHES = 4;

   localparam int KIND_W   = 4;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 16;
   localparam int EVENT_W  = 3;
   localparam int STATUS_W = 2;
   localparam int STATE_W  = 3;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [LEN_W-1:0]  len_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSTR      = 4'd0,
      KIND_ACCESS     = 4'd1,
      KIND_ADD_BP     = 4'd2,
      KIND_DEL_BP     = 4'd3,
      KIND_ADD_WATCH  = 4'd4,
      KIND_DEL_WATCH  = 4'd5,
      KIND_BRK_REQ    = 4'd6,
      KIND_SOFTBRK    = 4'd7,
      KIND_STEP       = 4'd8,
      KIND_CONTINUE   = 4'd9,
      KIND_DETACH     = 4'd10,
      KIND_ATTACH     = 4'd11
   } kind_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE     = 3'd0,
      EV_BREAK    = 3'd1,
      EV_RD_WATCH = 3'd2,
      EV_WR_WATCH = 3'd3,
      EV_TRAPPED  = 3'd4
   } event_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_FULL       = 2'd1,
      STAT_NOT_FOUND  = 2'd2,
      STAT_NOT_HALTED = 2'd3
   } status_type;

   // Last byte of a range, modulo 2^ADDR_W; a zero length wraps.
   function automatic addr_type last_byte(input addr_type first, input len_type len);
      return first + ADDR_W'(len) - ADDR_W'(1);
   endfunction

   function automatic logic in_span(input addr_type x, input addr_type lo,
                                    input addr_type hi);
      return (x >= lo) && (x <= hi);
   endfunction

   function automatic logic overlaps(input addr_type a, input addr_type a_last,
                                     input addr_type w, input addr_type w_last);
      return in_span(a, w, w_last) || in_span(a_last, w, w_last) ||
             in_span(w, a, a_last) || in_span(w_last, a, a_last);
   endfunction

endpackage
`default_nettype wire

// File: rtl/breakpoint_watchpoint_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint and watchpoint unit
// Debug run-state machine with a breakpoint table and read and write
// watch-range tables, checking instructions and memory accesses.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | kind, address, length, is_write
//   rsp     | out       | rsp_valid/rsp_stall | event_res, status, run_state,
//           |           |                     | trapped_address
//
// One transfer per clock sustained while rsp_stall is low; a result passes
// through the input register, then the result register.
// Run state and tables update in the cycle the item moves into the result
// register, so each item sees all earlier items' effects.
// Synchronous reset clears run state, valid bits, pending break and hit record.
// rsp_stall holds the result register and, with the input register full,
// stalls the request side in the same cycle.
// ----------------------------------------------------------------------------
module breakpoint_watchpoint_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [bwu_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [bwu_pkg::ADDR_W-1:0]    req_address,
   input  wire logic [bwu_pkg::LEN_W-1:0]     req_length,
   input  wire logic                          req_is_write,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [bwu_pkg::EVENT_W-1:0]        rsp_event_res,
   output logic [bwu_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bwu_pkg::STATE_W-1:0]        rsp_run_state,
   output logic [bwu_pkg::ADDR_W-1:0]         rsp_trapped_address
);
   import bwu_pkg::*;

   typedef enum logic [STATE_W-1:0] {
      ST_NORMAL    = 3'd0,
      ST_STEP      = 3'd1,
      ST_BREAK     = 3'd2,
      ST_PREWATCH  = 3'd3,
      ST_WATCH     = 3'd4,
      ST_POSTWATCH = 3'd5
   } mode_type;

   // input register
   logic       in_valid_ff;
   kind_type   in_kind_ff;
   addr_type   in_address_ff;
   len_type    in_length_ff;
   logic       in_is_write_ff;

   // result register
   logic       rsp_valid_ff;
   event_type  rsp_event_ff;
   status_type rsp_status_ff;
   mode_type   rsp_state_ff;
   addr_type   rsp_taddr_ff;

   // run state
   mode_type   mode_ff, mode_in;
   logic       pending_ff, pending_in;
   addr_type   hit_address_ff, hit_address_in;
   logic       hit_was_read_ff, hit_was_read_in;

   // tables
   addr_type   bp_address_ff [NUM_BREAKPOINTS];
   logic [NUM_BREAKPOINTS-1:0] bp_valid_ff, bp_valid_in;

   addr_type   rd_address_ff [NUM_READ_WATCHES];
   len_type    rd_length_ff  [NUM_READ_WATCHES];
   addr_type   rd_last_ff    [NUM_READ_WATCHES];
   logic [NUM_READ_WATCHES-1:0] rd_valid_ff, rd_valid_in;

   addr_type   wr_address_ff [NUM_WRITE_WATCHES];
   len_type    wr_length_ff  [NUM_WRITE_WATCHES];
   addr_type   wr_last_ff    [NUM_WRITE_WATCHES];
   logic [NUM_WRITE_WATCHES-1:0] wr_valid_ff, wr_valid_in;

   logic       advance, take, halted;
   addr_type   acc_last;

   logic [NUM_BREAKPOINTS-1:0]   bp_match, bp_free, bp_add_pick, bp_del_pick, bp_load;
   logic [NUM_READ_WATCHES-1:0]  rd_hit, rd_match, rd_free, rd_add_pick, rd_del_pick;
   logic [NUM_READ_WATCHES-1:0]  rd_load;
   logic [NUM_WRITE_WATCHES-1:0] wr_hit, wr_match, wr_free, wr_add_pick, wr_del_pick;
   logic [NUM_WRITE_WATCHES-1:0] wr_load;

   event_type  ev_in;
   status_type status_in;
   addr_type   taddr_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign take      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = rsp_event_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_run_state       = rsp_state_ff;
   assign rsp_trapped_address = rsp_taddr_ff;

   assign halted   = (mode_ff == ST_BREAK) || (mode_ff == ST_WATCH);
   assign acc_last = last_byte(in_address_ff, in_length_ff);

   always_comb begin
      for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
         bp_match[i] = bp_valid_ff[i] && (bp_address_ff[i] == in_address_ff);
      end
      for (int i = 0; i < NUM_READ_WATCHES; i++) begin
         rd_hit[i]   = rd_valid_ff[i] &&
                       overlaps(in_address_ff, acc_last, rd_address_ff[i], rd_last_ff[i]);
         rd_match[i] = rd_valid_ff[i] && (rd_address_ff[i] == in_address_ff) &&
                       (rd_length_ff[i] == in_length_ff);
      end
      for (int i = 0; i < NUM_WRITE_WATCHES; i++) begin
         wr_hit[i]   = wr_valid_ff[i] &&
                       overlaps(in_address_ff, acc_last, wr_address_ff[i], wr_last_ff[i]);
         wr_match[i] = wr_valid_ff[i] && (wr_address_ff[i] == in_address_ff) &&
                       (wr_length_ff[i] == in_length_ff);
      end
   end

   // lowest set bit of each vector
   assign bp_free     = ~bp_valid_ff;
   assign rd_free     = ~rd_valid_ff;
   assign wr_free     = ~wr_valid_ff;
   assign bp_add_pick = bp_free  & (~bp_free  + NUM_BREAKPOINTS'(1));
   assign rd_add_pick = rd_free  & (~rd_free  + NUM_READ_WATCHES'(1));
   assign wr_add_pick = wr_free  & (~wr_free  + NUM_WRITE_WATCHES'(1));
   assign bp_del_pick = bp_match & (~bp_match + NUM_BREAKPOINTS'(1));
   assign rd_del_pick = rd_match & (~rd_match + NUM_READ_WATCHES'(1));
   assign wr_del_pick = wr_match & (~wr_match + NUM_WRITE_WATCHES'(1));

   always_comb begin
      mode_in         = mode_ff;
      pending_in      = pending_ff;
      hit_address_in  = hit_address_ff;
      hit_was_read_in = hit_was_read_ff;
      bp_valid_in     = bp_valid_ff;
      rd_valid_in     = rd_valid_ff;
      wr_valid_in     = wr_valid_ff;
      bp_load         = '0;
      rd_load         = '0;
      wr_load         = '0;
      ev_in           = EV_NONE;
      status_in       = STAT_OK;
      taddr_in        = '0;

      unique case (in_kind_ff)
         KIND_INSTR: begin
            pending_in = 1'b0;
            priority if (halted) begin
               mode_in = mode_ff;
            end else if (mode_ff == ST_STEP) begin
               mode_in = ST_BREAK;
               ev_in   = EV_BREAK;
            end else if (mode_ff == ST_PREWATCH) begin
               mode_in  = ST_WATCH;
               ev_in    = hit_was_read_ff ? EV_RD_WATCH : EV_WR_WATCH;
               taddr_in = hit_address_ff;
            end else if ((|bp_match) || pending_ff) begin
               mode_in = ST_BREAK;
               ev_in   = EV_BREAK;
            end else begin
               mode_in = ST_NORMAL;
            end
         end
         KIND_ACCESS: begin
            if ((mode_ff == ST_NORMAL) && (in_is_write_ff ? (|wr_hit) : (|rd_hit))) begin
               mode_in         = ST_PREWATCH;
               hit_address_in  = in_address_ff;
               hit_was_read_in = !in_is_write_ff;
               ev_in           = EV_TRAPPED;
               taddr_in        = in_address_ff;
            end
         end
         KIND_ADD_BP: begin
            if (|bp_free) begin
               bp_load     = bp_add_pick;
               bp_valid_in = bp_valid_ff | bp_add_pick;
            end else begin
               status_in = STAT_FULL;
            end
         end
         KIND_DEL_BP: begin
            if (|bp_match) begin
               bp_valid_in = bp_valid_ff & ~bp_del_pick;
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         KIND_ADD_WATCH: begin
            if (in_is_write_ff) begin
               if (|wr_free) begin
                  wr_load     = wr_add_pick;
                  wr_valid_in = wr_valid_ff | wr_add_pick;
               end else begin
                  status_in = STAT_FULL;
               end
            end else begin
               if (|rd_free) begin
                  rd_load     = rd_add_pick;
                  rd_valid_in = rd_valid_ff | rd_add_pick;
               end else begin
                  status_in = STAT_FULL;
               end
            end
         end
         KIND_DEL_WATCH: begin
            if (in_is_write_ff) begin
               if (|wr_match) begin
                  wr_valid_in = wr_valid_ff & ~wr_del_pick;
               end else begin
                  status_in = STAT_NOT_FOUND;
               end
            end else begin
               if (|rd_match) begin
                  rd_valid_in = rd_valid_ff & ~rd_del_pick;
               end else begin
                  status_in = STAT_NOT_FOUND;
               end
            end
         end
         KIND_BRK_REQ: begin
            pending_in = 1'b1;
         end
         KIND_SOFTBRK: begin
            mode_in = ST_BREAK;
            ev_in   = EV_BREAK;
         end
         KIND_STEP: begin
            if (halted) begin
               mode_in = ST_STEP;
            end else begin
               status_in = STAT_NOT_HALTED;
            end
         end
         KIND_CONTINUE: begin
            if (halted) begin
               mode_in = (mode_ff == ST_WATCH) ? ST_POSTWATCH : ST_NORMAL;
            end else begin
               status_in = STAT_NOT_HALTED;
            end
         end
         KIND_DETACH: begin
            if (halted) begin
               bp_valid_in = '0;
               rd_valid_in = '0;
               wr_valid_in = '0;
               mode_in     = ST_NORMAL;
            end else begin
               status_in = STAT_NOT_HALTED;
            end
         end
         KIND_ATTACH: begin
            mode_in    = ST_BREAK;
            pending_in = 1'b0;
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         mode_ff         <= ST_NORMAL;
         pending_ff      <= 1'b0;
         hit_address_ff  <= '0;
         hit_was_read_ff <= 1'b0;
         bp_valid_ff     <= '0;
         rd_valid_ff     <= '0;
         wr_valid_ff     <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (take) begin
            mode_ff         <= mode_in;
            pending_ff      <= pending_in;
            hit_address_ff  <= hit_address_in;
            hit_was_read_ff <= hit_was_read_in;
            bp_valid_ff     <= bp_valid_in;
            rd_valid_ff     <= rd_valid_in;
            wr_valid_ff     <= wr_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff     <= kind_type'(req_kind);
         in_address_ff  <= req_address;
         in_length_ff   <= req_length;
         in_is_write_ff <= req_is_write;
      end
      if (take) begin
         rsp_event_ff  <= ev_in;
         rsp_status_ff <= status_in;
         rsp_state_ff  <= mode_in;
         rsp_taddr_ff  <= taddr_in;
         for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
            if (bp_load[i]) begin
               bp_address_ff[i] <= in_address_ff;
            end
         end
         for (int i = 0; i < NUM_READ_WATCHES; i++) begin
            if (rd_load[i]) begin
               rd_address_ff[i] <= in_address_ff;
               rd_length_ff[i]  <= in_length_ff;
               rd_last_ff[i]    <= acc_last;
            end
         end
         for (int i = 0; i < NUM_WRITE_WATCHES; i++) begin
            if (wr_load[i]) begin
               wr_address_ff[i] <= in_address_ff;
               wr_length_ff[i]  <= in_length_ff;
               wr_last_ff[i]    <= acc_last;
            end
         end
      end
   end

   a_state_tracks_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_state_ff == mode_ff))
      else $error("result run state differs from held run state");

   a_watch_event_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_event_ff == EV_RD_WATCH) || (rsp_event_ff == EV_WR_WATCH))
      |-> (rsp_state_ff == ST_WATCH))
      else $error("watch break reported outside watch state");

   a_trap_records_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_event_ff == EV_TRAPPED)
      |-> (mode_ff == ST_PREWATCH) && (hit_address_ff == rsp_taddr_ff))
      else $error("trapped access not recorded");

   a_status_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STAT_OK) |-> (rsp_event_ff == EV_NONE))
      else $error("event reported with failing status");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("request stalled with room to advance");

endmodule
`default_nettype wire

// File: dv/bwu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint/watchpoint unit checker
// Watches the request and result channels of the unit, runs its own model
// of the run states and the breakpoint and watch tables on every request
// transfer, and compares every result transfer field by field against the
// oldest predicted result. Reports the mismatch count and the number of
// results still outstanding.
// ----------------------------------------------------------------------------
module bwu_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic [bwu_pkg::KIND_W-1:0] req_kind,
   input  wire logic [bwu_pkg::ADDR_W-1:0] req_address,
   input  wire logic [bwu_pkg::LEN_W-1:0]  req_length,
   input  wire logic                       req_is_write,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [bwu_pkg::EVENT_W-1:0]  rsp_event_res,
   input  wire logic [bwu_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic [bwu_pkg::STATE_W-1:0]  rsp_run_state,
   input  wire logic [bwu_pkg::ADDR_W-1:0]   rsp_trapped_address,
   output int                              fail_count,
   output int                              pending
);
   import bwu_pkg::*;

   localparam int MAX_REPORTS = 10;
   localparam int WATCH_DEPTH = (NUM_READ_WATCHES > NUM_WRITE_WATCHES) ?
                                NUM_READ_WATCHES : NUM_WRITE_WATCHES;
   localparam int RD_TABLE = 0;
   localparam int WR_TABLE = 1;

   typedef enum logic [STATE_W-1:0] {
      RS_NORMAL    = 3'd0,
      RS_STEP      = 3'd1,
      RS_BREAK     = 3'd2,
      RS_PREWATCH  = 3'd3,
      RS_WATCH     = 3'd4,
      RS_POSTWATCH = 3'd5
   } run_state_type;

   typedef struct packed {
      event_type     ev;
      status_type    status;
      run_state_type state;
      addr_type      taddr;
   } debug_result_t;

   run_state_type mode;
   addr_type      bp_addr  [NUM_BREAKPOINTS];
   logic          bp_on    [NUM_BREAKPOINTS];
   addr_type      watch_addr [2][WATCH_DEPTH];
   len_type       watch_len  [2][WATCH_DEPTH];
   logic          watch_on   [2][WATCH_DEPTH];
   addr_type      hit_addr;
   logic          hit_read;
   logic          brk_pending;

   debug_result_t expected_results [$];
   int            errors = 0;

   function automatic void clear_tables();
      for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
         bp_addr[i] = '0;
         bp_on[i]   = 1'b0;
      end
      for (int t = 0; t < 2; t++) begin
         for (int i = 0; i < WATCH_DEPTH; i++) begin
            watch_addr[t][i] = '0;
            watch_len[t][i]  = '0;
            watch_on[t][i]   = 1'b0;
         end
      end
   endfunction

   function automatic logic in_range(input addr_type x, input addr_type lo,
                                     input addr_type hi);
      return (x >= lo) && (x <= hi);
   endfunction

   // End of a range wraps modulo 2^32; a zero length spans up to first - 1.
   function automatic logic ranges_meet(input addr_type a, input len_type alen,
                                        input addr_type w, input len_type wlen);
      addr_type a_end;
      addr_type w_end;
      a_end = a + {{(ADDR_W-LEN_W){1'b0}}, alen} - {{(ADDR_W-1){1'b0}}, 1'b1};
      w_end = w + {{(ADDR_W-LEN_W){1'b0}}, wlen} - {{(ADDR_W-1){1'b0}}, 1'b1};
      return in_range(a, w, w_end) || in_range(a_end, w, w_end) ||
             in_range(w, a, a_end) || in_range(w_end, a, a_end);
   endfunction

   function automatic debug_result_t apply_item(input logic [KIND_W-1:0] kind,
                                                input addr_type addr,
                                                input len_type len,
                                                input logic wr);
      debug_result_t r;
      logic          user;
      logic          hit;
      logic          done;
      logic          halted;
      int            tbl;
      int            depth;
      r.ev     = EV_NONE;
      r.status = STAT_OK;
      r.taddr  = '0;
      hit      = 1'b0;
      done     = 1'b0;
      halted   = (mode == RS_BREAK) || (mode == RS_WATCH);
      tbl      = wr ? WR_TABLE : RD_TABLE;
      depth    = wr ? NUM_WRITE_WATCHES : NUM_READ_WATCHES;
      case (kind)
         KIND_INSTR: begin
            user        = brk_pending;
            brk_pending = 1'b0;
            if (!halted) begin
               if (mode == RS_STEP) begin
                  mode = RS_BREAK;
                  r.ev = EV_BREAK;
               end else if (mode == RS_PREWATCH) begin
                  mode    = RS_WATCH;
                  r.taddr = hit_addr;
                  if (hit_read) r.ev = EV_RD_WATCH;
                  else r.ev = EV_WR_WATCH;
               end else begin
                  mode = RS_NORMAL;
                  for (int i = 0; i < NUM_BREAKPOINTS; i++)
                     if (bp_on[i] && bp_addr[i] == addr) hit = 1'b1;
                  if (hit || user) begin
                     mode = RS_BREAK;
                     r.ev = EV_BREAK;
                  end
               end
            end
         end
         KIND_ACCESS: begin
            if (mode == RS_NORMAL) begin
               for (int i = 0; i < depth; i++)
                  if (watch_on[tbl][i] &&
                      ranges_meet(addr, len, watch_addr[tbl][i], watch_len[tbl][i]))
                     hit = 1'b1;
               if (hit) begin
                  mode     = RS_PREWATCH;
                  hit_addr = addr;
                  hit_read = !wr;
                  r.ev     = EV_TRAPPED;
                  r.taddr  = addr;
               end
            end
         end
         KIND_ADD_BP: begin
            r.status = STAT_FULL;
            for (int i = 0; i < NUM_BREAKPOINTS; i++)
               if (!done && !bp_on[i]) begin
                  bp_on[i]   = 1'b1;
                  bp_addr[i] = addr;
                  r.status   = STAT_OK;
                  done       = 1'b1;
               end
         end
         KIND_DEL_BP: begin
            r.status = STAT_NOT_FOUND;
            for (int i = 0; i < NUM_BREAKPOINTS; i++)
               if (!done && bp_on[i] && bp_addr[i] == addr) begin
                  bp_on[i] = 1'b0;
                  r.status = STAT_OK;
                  done     = 1'b1;
               end
         end
         KIND_ADD_WATCH: begin
            r.status = STAT_FULL;
            for (int i = 0; i < depth; i++)
               if (!done && !watch_on[tbl][i]) begin
                  watch_on[tbl][i]   = 1'b1;
                  watch_addr[tbl][i] = addr;
                  watch_len[tbl][i]  = len;
                  r.status           = STAT_OK;
                  done               = 1'b1;
               end
         end
         KIND_DEL_WATCH: begin
            r.status = STAT_NOT_FOUND;
            for (int i = 0; i < depth; i++)
               if (!done && watch_on[tbl][i] && watch_addr[tbl][i] == addr &&
                   watch_len[tbl][i] == len) begin
                  watch_on[tbl][i] = 1'b0;
                  r.status         = STAT_OK;
                  done             = 1'b1;
               end
         end
         KIND_BRK_REQ: brk_pending = 1'b1;
         KIND_SOFTBRK: begin
            mode = RS_BREAK;
            r.ev = EV_BREAK;
         end
         KIND_STEP: begin
            if (!halted) r.status = STAT_NOT_HALTED;
            else mode = RS_STEP;
         end
         KIND_CONTINUE: begin
            if (!halted) r.status = STAT_NOT_HALTED;
            else if (mode == RS_WATCH) mode = RS_POSTWATCH;
            else mode = RS_NORMAL;
         end
         KIND_DETACH: begin
            if (!halted) begin
               r.status = STAT_NOT_HALTED;
            end else begin
               clear_tables();
               mode = RS_NORMAL;
            end
         end
         KIND_ATTACH: begin
            mode        = RS_BREAK;
            brk_pending = 1'b0;
         end
         default: begin
            r.ev = EV_NONE;
         end
      endcase
      r.state = mode;
      return r;
   endfunction

   always @(posedge clock) begin
      debug_result_t want;
      if (reset) begin
         clear_tables();
         mode        = RS_NORMAL;
         hit_addr    = '0;
         hit_read    = 1'b0;
         brk_pending = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("ERROR %0t: unexpected result ev=%0d st=%0d rs=%0d ta=%h",
                           $time, rsp_event_res, rsp_status, rsp_run_state,
                           rsp_trapped_address);
            end else begin
               want = expected_results.pop_front();
               if (rsp_event_res !== want.ev || rsp_status !== want.status ||
                   rsp_run_state !== want.state || rsp_trapped_address !== want.taddr) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display({"ERROR %0t: exp ev=%0d st=%0d rs=%0d ta=%h",
                               " got ev=%0d st=%0d rs=%0d ta=%h"},
                              $time, want.ev, want.status, want.state, want.taddr,
                              rsp_event_res, rsp_status, rsp_run_state,
                              rsp_trapped_address);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(apply_item(req_kind, req_address,
                                                  req_length, req_is_write));
      end
      fail_count <= errors;
      pending    <= expected_results.size();
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint/watchpoint unit testbench
// Drives a directed sequence through every run state and table corner, then
// weighted random traffic over a small address pool so breakpoints and watch
// ranges hit often. Both channels idle at random except in one quiet stretch.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import bwu_pkg::*;

   localparam int RANDOM_ITEMS = 1050;
   localparam int IDLE_PCT     = 15;
   localparam int QUIET_FIRST  = 400;
   localparam int QUIET_LAST   = 600;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int POOL_SIZE    = 8;
   localparam int WATCH_MEMORY = 16;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd12;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

   typedef struct {
      addr_type addr;
      len_type  len;
      logic     wr;
   } watch_rec_type;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic [KIND_W-1:0]     req_kind     = '0;
   logic [ADDR_W-1:0]     req_address  = '0;
   logic [LEN_W-1:0]      req_length   = '0;
   logic                  req_is_write = 1'b0;
   logic                  rsp_stall    = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [EVENT_W-1:0]    rsp_event_res;
   logic [STATUS_W-1:0]   rsp_status;
   logic [STATE_W-1:0]    rsp_run_state;
   logic [ADDR_W-1:0]     rsp_trapped_address;
   logic                  quiet        = 1'b0;
   int                    fail_count;
   int                    pending;
   int                    idle_cycles  = 0;
   addr_type              addr_pool [POOL_SIZE];
   watch_rec_type         watches [$];

   breakpoint_watchpoint_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_address         (req_address),
      .req_length          (req_length),
      .req_is_write        (req_is_write),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_res       (rsp_event_res),
      .rsp_status          (rsp_status),
      .rsp_run_state       (rsp_run_state),
      .rsp_trapped_address (rsp_trapped_address)
   );

   bwu_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_address         (req_address),
      .req_length          (req_length),
      .req_is_write        (req_is_write),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_res       (rsp_event_res),
      .rsp_status          (rsp_status),
      .rsp_run_state       (rsp_run_state),
      .rsp_trapped_address (rsp_trapped_address),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send(input logic [KIND_W-1:0] kind, input addr_type addr,
                       input len_type len, input logic wr);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_address  <= addr;
      req_length   <= len;
      req_is_write <= wr;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_item();
      int                pick;
      addr_type          addr;
      len_type           len;
      logic              wr;
      logic [KIND_W-1:0] kind;
      watch_rec_type     w;
      pick = $urandom_range(99);
      wr   = 1'($urandom_range(1));
      if ($urandom_range(3) == 0) addr = $urandom;
      else addr = addr_pool[$urandom_range(POOL_SIZE-1)];
      case ($urandom_range(7))
         0:       len = len_type'($urandom);
         1:       len = '0;
         2:       len = '1;
         default: len = len_type'(1) << $urandom_range(5);
      endcase
      if (pick < 28) begin
         kind = KIND_INSTR;
      end else if (pick < 50) begin
         kind = KIND_ACCESS;
         addr = addr - addr_type'($urandom_range(24));
      end else if (pick < 56) begin
         kind = KIND_ADD_BP;
      end else if (pick < 61) begin
         kind = KIND_DEL_BP;
      end else if (pick < 69) begin
         kind = KIND_ADD_WATCH;
         watches.push_back('{addr, len, wr});
         if (watches.size() > WATCH_MEMORY) void'(watches.pop_front());
      end else if (pick < 74) begin
         kind = KIND_DEL_WATCH;
         if (watches.size() != 0 && $urandom_range(3) != 0) begin
            w    = watches[$urandom_range(watches.size() - 1)];
            addr = w.addr;
            len  = w.len;
            wr   = w.wr;
         end
      end else if (pick < 78) begin
         kind = KIND_BRK_REQ;
      end else if (pick < 80) begin
         kind = KIND_SOFTBRK;
      end else if (pick < 86) begin
         kind = KIND_STEP;
      end else if (pick < 96) begin
         kind = KIND_CONTINUE;
      end else if (pick < 97) begin
         kind = KIND_DETACH;
      end else if (pick < 98) begin
         kind = KIND_ATTACH;
      end else begin
         kind = KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      end
      send(kind, addr, len, wr);
   endtask

   initial begin
      addr_pool[0] = 32'h0000_0000;
      addr_pool[1] = 32'hFFFF_FFF0;
      addr_pool[2] = 32'h8000_0000;
      addr_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: table corners, every run state, wrapped and zero-length ranges
      send(KIND_STEP,      32'h0000_0000, 16'd1,      1'b0);
      send(KIND_ATTACH,    32'h0000_0000, 16'd1,      1'b0);
      send(KIND_ADD_BP,    32'h0000_1000, 16'd1,      1'b0);
      send(KIND_ADD_BP,    32'hFFFF_FFFF, 16'hFFFF,   1'b1);
      send(KIND_ADD_BP,    32'h0000_0000, 16'd1,      1'b0);
      send(KIND_ADD_BP,    32'h8000_0000, 16'd1,      1'b0);
      send(KIND_ADD_BP,    32'h0000_1234, 16'd1,      1'b0);
      send(KIND_DEL_BP,    32'h0000_5555, 16'd1,      1'b0);
      send(KIND_DEL_BP,    32'h0000_0000, 16'd1,      1'b0);
      send(KIND_ADD_WATCH, 32'h0000_2000, 16'd16,     1'b0);
      send(KIND_ADD_WATCH, 32'hFFFF_FFF0, 16'hFFFF,   1'b1);
      send(KIND_CONTINUE,  32'h0000_0000, 16'd1,      1'b0);
      send(KIND_INSTR,     32'h0000_1000, 16'd1,      1'b0);
      send(KIND_STEP,      32'h0000_0000, 16'd1,      1'b0);
      send(KIND_INSTR,     32'h0000_1004, 16'd1,      1'b0);
      send(KIND_CONTINUE,  32'h0000_0000, 16'd1,      1'b0);
      send(KIND_ACCESS,    32'hFFFF_FFEE, 16'd16,     1'b1);
      send(KIND_ACCESS,    32'h0000_2008, 16'd1,      1'b0);
      send(KIND_INSTR,     32'h0000_1008, 16'd1,      1'b0);
      send(KIND_CONTINUE,  32'h0000_0000, 16'd1,      1'b0);
      send(KIND_BRK_REQ,   32'h0000_0000, 16'd1,      1'b0);
      send(KIND_INSTR,     32'h0000_100C, 16'd1,      1'b0);
      send(KIND_ADD_WATCH, 32'h0000_4000, 16'd0,      1'b0);
      send(KIND_DEL_WATCH, 32'h0000_2000, 16'd16,     1'b1);
      send(KIND_DETACH,    32'h0000_0000, 16'd1,      1'b0);
      send(KIND_CONTINUE,  32'h0000_0000, 16'd1,      1'b0);
      send(KIND_SOFTBRK,   32'h0000_0000, 16'd1,      1'b0);
      send(KIND_UNUSED_HI, 32'hFFFF_FFFF, 16'hFFFF,   1'b1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= QUIET_FIRST) && (n < QUIET_LAST);
         random_item();
      end
      quiet = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
